// ===== sv/assert_macros.svh =====
// assertion macros for the rtl of the pair distance block, included by the top file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mipd_pkg.sv =====
// shared types and constants of the minimum-image pair distance pipeline
package mipd_pkg;

    // pipeline stage numbers
    localparam int NUM_STAGES = 9;
    localparam int STG_DIFF   = 0;
    localparam int STG_MAG    = 1;
    localparam int STG_PROD   = 2;
    localparam int STG_COUNT  = 3;
    localparam int STG_SHIFT  = 4;
    localparam int STG_SEP    = 5;
    localparam int STG_SQ     = 6;
    localparam int STG_SUM    = 7;
    localparam int STG_OUT    = 8;

    // field widths
    localparam int COORD_W  = 32;
    localparam int RADIUS_W = 30;
    localparam int LEN_W    = 31;
    localparam int RECIP_W  = 33;
    localparam int CUT_W    = 31;
    localparam int DSQ_W    = 62;
    localparam int THR_W    = 33;
    localparam int CFG_W    = 33;
    localparam int IDX_W    = 3;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_LENGTH_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_LENGTH_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_LENGTH_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_RECIP_X  = 3'd3;
    localparam logic [IDX_W-1:0] REG_RECIP_Y  = 3'd4;
    localparam logic [IDX_W-1:0] REG_RECIP_Z  = 3'd5;
    localparam logic [IDX_W-1:0] REG_CUTOFF   = 3'd6;

    // register reset values
    localparam logic [LEN_W-1:0]   LENGTH_RESET = 31'h7FFF_FFFF;
    localparam logic [RECIP_W-1:0] RECIP_RESET  = 33'd131072;
    localparam logic [CUT_W-1:0]   CUTOFF_RESET = 31'd0;

    // largest separation magnitude, 2^30 as a raw value, that is 16384.0 in Q16.16
    localparam logic signed [COORD_W-1:0] SEP_MAX = 32'sd1073741824;
    localparam logic signed [COORD_W-1:0] SEP_MIN = -32'sd1073741824;

    // per-stage load strobes from the pipeline control
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctl_t;

endpackage

// ===== sv/minimum_image_pair_distance_top.sv =====
// Minimum-image pair distance: takes one point pair per cycle, unless the output
// stalls, and returns the periodic-box separation, its squared length and the
// cutoff flag. Throughput is one transfer per clock while the output is not
// stalled; each pair passes through the nine register stages (difference, magnitude,
// reciprocal product, rounding, wrap multiply, fold, square, sum, compare),
// the first of which loads at the input transfer edge.
// Each stage holds its own valid bit, so empty stages keep filling while the
// output waits. The user must write the registers through cfg_we/cfg_index/cfg_data
// only while no transfer is in flight; the block itself does not enforce this.
module minimum_image_pair_distance_top (
    input  logic         clk,
    input  logic         rst_n,
    // configuration writes
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [32:0]  cfg_data,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z,
    // first_radius, second_radius, zero pad
    input  logic [255:0] s_axis_tdata,
    // output stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // sep_x, sep_y, sep_z, dist_sq, beyond_cutoff, zero pad
    output logic [159:0] m_axis_tdata
);
    import mipd_pkg::*;

    `include "assert_macros.svh"

    localparam int SQ_W = 2 * COORD_W;

    logic [LEN_W-1:0]   length_x_reg, length_y_reg, length_z_reg;
    logic [RECIP_W-1:0] recip_x_reg, recip_y_reg, recip_z_reg;
    logic [CUT_W-1:0]   cutoff_reg;

    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES-1:0] ready;
    pipe_ctl_t             ctl;

    logic signed [COORD_W-1:0] first_x, first_y, first_z;
    logic signed [COORD_W-1:0] second_x, second_y, second_z;
    logic [RADIUS_W-1:0]       first_radius, second_radius;

    logic signed [COORD_W-1:0] sep6_x, sep6_y, sep6_z;
    logic [DSQ_W-1:0]          sq6_x, sq6_y, sq6_z;
    logic                      thr_ok;
    logic [SQ_W-1:0]           thr_sq;

    logic signed [COORD_W-1:0] sep7_x_reg, sep7_y_reg, sep7_z_reg;
    logic [DSQ_W-1:0]          dsq7_reg;
    logic signed [COORD_W-1:0] sep_x_reg, sep_y_reg, sep_z_reg;
    logic [DSQ_W-1:0]          dsq_reg;
    logic                      beyond_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_x_reg <= LENGTH_RESET;
            length_y_reg <= LENGTH_RESET;
            length_z_reg <= LENGTH_RESET;
            recip_x_reg  <= RECIP_RESET;
            recip_y_reg  <= RECIP_RESET;
            recip_z_reg  <= RECIP_RESET;
            cutoff_reg   <= CUTOFF_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LENGTH_X: length_x_reg <= cfg_data[LEN_W-1:0];
                REG_LENGTH_Y: length_y_reg <= cfg_data[LEN_W-1:0];
                REG_LENGTH_Z: length_z_reg <= cfg_data[LEN_W-1:0];
                REG_RECIP_X:  recip_x_reg  <= cfg_data;
                REG_RECIP_Y:  recip_y_reg  <= cfg_data;
                REG_RECIP_Z:  recip_z_reg  <= cfg_data;
                REG_CUTOFF:   cutoff_reg   <= cfg_data[CUT_W-1:0];
                default: ;
            endcase
        end
    end

    // stage advance: a stage loads when it is empty or its successor moves
    always_comb
    begin
        ready[STG_OUT] = !valid_reg[STG_OUT] || m_axis_tready;
        for (int k = STG_OUT - 1; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
        valid_next[STG_DIFF] = ready[STG_DIFF] ? s_axis_tvalid : valid_reg[STG_DIFF];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            valid_next[k] = ready[k] ? valid_reg[k-1] : valid_reg[k];
        end
        ctl.load = ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_axis_tready = ready[STG_DIFF];
    assign m_axis_tvalid = valid_reg[STG_OUT];

    // input unpacking
    assign first_x       = s_axis_tdata[31:0];
    assign first_y       = s_axis_tdata[63:32];
    assign first_z       = s_axis_tdata[95:64];
    assign second_x      = s_axis_tdata[127:96];
    assign second_y      = s_axis_tdata[159:128];
    assign second_z      = s_axis_tdata[191:160];
    assign first_radius  = s_axis_tdata[221:192];
    assign second_radius = s_axis_tdata[251:222];

    // per-axis fold pipelines
    mipd_axis u_axis_x (
        .clk    (clk),
        .ctl    (ctl),
        .first  (first_x),
        .second (second_x),
        .len    (length_x_reg),
        .recip  (recip_x_reg),
        .sep    (sep6_x),
        .sq     (sq6_x)
    );

    mipd_axis u_axis_y (
        .clk    (clk),
        .ctl    (ctl),
        .first  (first_y),
        .second (second_y),
        .len    (length_y_reg),
        .recip  (recip_y_reg),
        .sep    (sep6_y),
        .sq     (sq6_y)
    );

    mipd_axis u_axis_z (
        .clk    (clk),
        .ctl    (ctl),
        .first  (first_z),
        .second (second_z),
        .len    (length_z_reg),
        .recip  (recip_z_reg),
        .sep    (sep6_z),
        .sq     (sq6_z)
    );

    // cutoff threshold
    mipd_thresh u_thresh (
        .clk           (clk),
        .ctl           (ctl),
        .cutoff        (cutoff_reg),
        .first_radius  (first_radius),
        .second_radius (second_radius),
        .thr_ok        (thr_ok),
        .thr_sq        (thr_sq)
    );

    // sum of squares
    always_ff @(posedge clk)
    begin
        if (ready[STG_SUM])
        begin
            dsq7_reg   <= sq6_x + sq6_y + sq6_z;
            sep7_x_reg <= sep6_x;
            sep7_y_reg <= sep6_y;
            sep7_z_reg <= sep6_z;
        end
    end

    // cutoff compare and output register
    always_ff @(posedge clk)
    begin
        if (ready[STG_OUT])
        begin
            dsq_reg    <= dsq7_reg;
            beyond_reg <= thr_ok && (SQ_W'(dsq7_reg) > thr_sq);
            sep_x_reg  <= sep7_x_reg;
            sep_y_reg  <= sep7_y_reg;
            sep_z_reg  <= sep7_z_reg;
        end
    end

    assign m_axis_tdata = {1'b0, beyond_reg, dsq_reg, sep_z_reg, sep_y_reg, sep_x_reg};

    // checks
    `ASSERT_IMPL(a_full_when_blocked, !s_axis_tready, &valid_reg,
        "input blocked while a pipeline stage is empty")
    `ASSERT_IMPL(a_sep_range, m_axis_tvalid,
        (sep_x_reg <= SEP_MAX) && (sep_x_reg >= SEP_MIN) &&
        (sep_y_reg <= SEP_MAX) && (sep_y_reg >= SEP_MIN) &&
        (sep_z_reg <= SEP_MAX) && (sep_z_reg >= SEP_MIN),
        "separation outside saturation range")
    `ASSERT_IMPL(a_beyond_nonzero, m_axis_tvalid && beyond_reg, dsq_reg != '0,
        "beyond flag set on zero distance")
    `ASSERT_NEXT(a_sum_moves_out, valid_reg[STG_SUM] && ready[STG_OUT], m_axis_tvalid,
        "item lost between sum and output stage")

endmodule

// ===== sv/mipd_axis.sv =====
// one axis of the minimum-image fold: difference, wrap count, saturation and square
module mipd_axis (
    input  logic                                   clk,
    input  mipd_pkg::pipe_ctl_t                    ctl,
    input  logic signed [mipd_pkg::COORD_W-1:0]    first,
    input  logic signed [mipd_pkg::COORD_W-1:0]    second,
    input  logic        [mipd_pkg::LEN_W-1:0]      len,
    input  logic        [mipd_pkg::RECIP_W-1:0]    recip,
    output logic signed [mipd_pkg::COORD_W-1:0]    sep,
    output logic        [mipd_pkg::DSQ_W-1:0]      sq
);
    import mipd_pkg::*;

    localparam int DIFF_W  = COORD_W + 1;
    localparam int MAG_W   = COORD_W;
    localparam int PROD_W  = 2 * MAG_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int CNT_W   = 18;
    localparam int SHIFT_W = CNT_W + LEN_W;
    localparam int WRAP_W  = SHIFT_W + 1;
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << 47;
    localparam logic signed [WRAP_W-1:0] WRAP_MAX = WRAP_W'(SEP_MAX);
    localparam logic signed [WRAP_W-1:0] WRAP_MIN = WRAP_W'(SEP_MIN);

    logic signed [DIFF_W-1:0]  diff0_reg, diff1_reg, diff2_reg, diff3_reg, diff4_reg;
    logic                      neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic                      out1_reg, out2_reg, out3_reg, out4_reg;
    logic        [MAG_W-1:0]   mag_reg;
    logic        [PROD_W-1:0]  prod_lo_reg;
    logic        [MAG_W-1:0]   prod_hi_reg;
    logic        [CNT_W-1:0]   count_reg;
    logic        [SHIFT_W-1:0] shift_reg;
    logic signed [COORD_W-1:0] sep5_reg, sep6_reg;
    logic        [DSQ_W-1:0]   sq_reg;

    logic signed [DIFF_W-1:0]  mag_full;
    logic        [ACC_W-1:0]   acc;
    logic signed [WRAP_W-1:0]  diff_ext, shift_ext, wrapped;
    logic signed [COORD_W-1:0] sep_sat;
    logic signed [PROD_W-1:0]  sq_full;

    // difference of second minus first
    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_DIFF])
        begin
            diff0_reg <= $signed({second[COORD_W-1], second}) -
                         $signed({first[COORD_W-1], first});
        end
    end

    // magnitude and half-box test
    always_comb
    begin
        mag_full = diff0_reg[DIFF_W-1] ? -diff0_reg : diff0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_MAG])
        begin
            mag_reg   <= mag_full[MAG_W-1:0];
            neg1_reg  <= diff0_reg[DIFF_W-1];
            out1_reg  <= {mag_full[MAG_W-1:0], 1'b0} > {2'b00, len};
            diff1_reg <= diff0_reg;
        end
    end

    // magnitude times reciprocal, low 32 bits of the reciprocal plus its top bit
    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_PROD])
        begin
            prod_lo_reg <= PROD_W'(mag_reg) * PROD_W'(recip[RECIP_W-2:0]);
            prod_hi_reg <= recip[RECIP_W-1] ? mag_reg : '0;
            neg2_reg    <= neg1_reg;
            out2_reg    <= out1_reg;
            diff2_reg   <= diff1_reg;
        end
    end

    // rounded wrap count
    always_comb
    begin
        acc = ACC_W'(prod_lo_reg) + ACC_W'({prod_hi_reg, 32'd0}) + ROUND_HALF;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_COUNT])
        begin
            count_reg <= acc[ACC_W-1:48];
            neg3_reg  <= neg2_reg;
            out3_reg  <= out2_reg;
            diff3_reg <= diff2_reg;
        end
    end

    // wrap distance as count times edge length
    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_SHIFT])
        begin
            shift_reg <= SHIFT_W'(count_reg) * SHIFT_W'(len);
            neg4_reg  <= neg3_reg;
            out4_reg  <= out3_reg;
            diff4_reg <= diff3_reg;
        end
    end

    // fold back toward zero and saturate
    always_comb
    begin
        diff_ext  = WRAP_W'(diff4_reg);
        shift_ext = $signed({1'b0, shift_reg});
        if (!out4_reg)
        begin
            wrapped = diff_ext;
        end
        else if (neg4_reg)
        begin
            wrapped = diff_ext + shift_ext;
        end
        else
        begin
            wrapped = diff_ext - shift_ext;
        end
        priority if (wrapped > WRAP_MAX)
        begin
            sep_sat = SEP_MAX;
        end
        else if (wrapped < WRAP_MIN)
        begin
            sep_sat = SEP_MIN;
        end
        else
        begin
            sep_sat = wrapped[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_SEP])
        begin
            sep5_reg <= sep_sat;
        end
    end

    // square of the separation
    always_comb
    begin
        sq_full = PROD_W'(sep5_reg) * PROD_W'(sep5_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_SQ])
        begin
            sq_reg   <= sq_full[DSQ_W-1:0];
            sep6_reg <= sep5_reg;
        end
    end

    assign sep = sep6_reg;
    assign sq  = sq_reg;

endmodule

// ===== sv/mipd_thresh.sv =====
// threshold square for the cutoff test, carried along to the sum stage
module mipd_thresh (
    input  logic                                clk,
    input  mipd_pkg::pipe_ctl_t                 ctl,
    input  logic [mipd_pkg::CUT_W-1:0]          cutoff,
    input  logic [mipd_pkg::RADIUS_W-1:0]       first_radius,
    input  logic [mipd_pkg::RADIUS_W-1:0]       second_radius,
    output logic                                thr_ok,
    output logic [2*mipd_pkg::COORD_W-1:0]      thr_sq
);
    import mipd_pkg::*;

    localparam int SQ_W = 2 * COORD_W;

    logic [THR_W-1:0] thr0_reg, thr1_reg;
    logic [SQ_W-1:0]  sq_dly_reg [STG_PROD:STG_SUM];
    logic             ok_dly_reg [STG_PROD:STG_SUM];

    // cutoff plus both radii
    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_DIFF])
        begin
            thr0_reg <= THR_W'(cutoff) + THR_W'(first_radius) + THR_W'(second_radius);
        end
        if (ctl.load[STG_MAG])
        begin
            thr1_reg <= thr0_reg;
        end
    end

    // square of the threshold; at 2^32 or more nothing lies beyond it
    // then the delay line up to the sum stage
    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_PROD])
        begin
            sq_dly_reg[STG_PROD] <= SQ_W'(thr1_reg[COORD_W-1:0]) *
                                    SQ_W'(thr1_reg[COORD_W-1:0]);
            ok_dly_reg[STG_PROD] <= !thr1_reg[THR_W-1];
        end
        for (int k = STG_COUNT; k <= STG_SUM; k++)
        begin
            if (ctl.load[k])
            begin
                sq_dly_reg[k] <= sq_dly_reg[k-1];
                ok_dly_reg[k] <= ok_dly_reg[k-1];
            end
        end
    end

    assign thr_sq = sq_dly_reg[STG_SUM];
    assign thr_ok = ok_dly_reg[STG_SUM];

endmodule

// ===== verif/tb_minimum_image_pair_distance_top.sv =====
// testbench for the minimum-image pair distance block: directed and random pairs
module tb_minimum_image_pair_distance_top;
    import mipd_pkg::*;

    // write to this index must leave every register alone
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int STALL_LIMIT = 2000;
    localparam int BLOCK_ITEMS = 50;

    typedef struct {
        logic signed [COORD_W-1:0] first_x, first_y, first_z;
        logic signed [COORD_W-1:0] second_x, second_y, second_z;
        logic [RADIUS_W-1:0]       first_radius, second_radius;
    } point_pair_t;

    typedef struct {
        logic signed [COORD_W-1:0] sep_x, sep_y, sep_z;
        logic [DSQ_W-1:0]          dist_sq;
        logic                      beyond_cutoff;
    } separation_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [32:0]  cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // first_x, first_y, first_z, second_x, second_y, second_z,
    // first_radius, second_radius, zero pad
    logic [255:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // sep_x, sep_y, sep_z, dist_sq, beyond_cutoff, zero pad
    logic [159:0] m_axis_tdata;

    // shadow copy of the box registers
    logic [LEN_W-1:0]   box_len [3] = '{LENGTH_RESET, LENGTH_RESET, LENGTH_RESET};
    logic [RECIP_W-1:0] box_recip [3] = '{RECIP_RESET, RECIP_RESET, RECIP_RESET};
    logic [CUT_W-1:0]   cut_dist = CUTOFF_RESET;

    separation_t expected_separations [$];
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;

    minimum_image_pair_distance_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // uniform value in [lo, hi]
    function automatic longint pick_span(longint lo, longint hi);
        longint unsigned r;
        r = {$urandom, $urandom};
        return lo + longint'(r % longint'(hi - lo + 1));
    endfunction

    // fold one axis difference back into the box, then clamp to +-2^30
    function automatic logic signed [COORD_W-1:0] fold_into_box(
        logic signed [COORD_W-1:0] a, logic signed [COORD_W-1:0] b,
        logic [LEN_W-1:0] len, logic [RECIP_W-1:0] rcp);
        longint d;
        longint s;
        longint shift;
        logic [32:0] mag;
        logic [127:0] wraps;
        d = longint'(b) - longint'(a);
        mag = (d < 0) ? 33'(-d) : 33'(d);
        s = d;
        if (2 * longint'(mag) > longint'(len))
        begin
            // round half away from zero through the reciprocal
            wraps = (128'(mag) * 128'(rcp) + (128'd1 << 47)) >> 48;
            shift = longint'(wraps[63:0]) * longint'(len);
            s = (d < 0) ? d + shift : d - shift;
        end
        if (s > longint'(SEP_MAX))
            s = longint'(SEP_MAX);
        if (s < longint'(SEP_MIN))
            s = longint'(SEP_MIN);
        return s[COORD_W-1:0];
    endfunction

    function automatic separation_t predict_separation(point_pair_t p);
        separation_t r;
        longint unsigned mx, my, mz, dsq, thr;
        r.sep_x = fold_into_box(p.first_x, p.second_x, box_len[0], box_recip[0]);
        r.sep_y = fold_into_box(p.first_y, p.second_y, box_len[1], box_recip[1]);
        r.sep_z = fold_into_box(p.first_z, p.second_z, box_len[2], box_recip[2]);
        mx = (r.sep_x < 0) ? -longint'(r.sep_x) : longint'(r.sep_x);
        my = (r.sep_y < 0) ? -longint'(r.sep_y) : longint'(r.sep_y);
        mz = (r.sep_z < 0) ? -longint'(r.sep_z) : longint'(r.sep_z);
        dsq = mx * mx + my * my + mz * mz;
        r.dist_sq = dsq[DSQ_W-1:0];
        thr = 64'(cut_dist) + 64'(p.first_radius) + 64'(p.second_radius);
        // a threshold of 2^32 or more is never exceeded
        r.beyond_cutoff = (thr < 64'h1_0000_0000) && (dsq > thr * thr);
        return r;
    endfunction

    function automatic point_pair_t make_pair(
        longint ax, longint ay, longint az, longint bx, longint by, longint bz,
        longint ra, longint rb);
        point_pair_t p;
        p.first_x = ax[31:0];
        p.first_y = ay[31:0];
        p.first_z = az[31:0];
        p.second_x = bx[31:0];
        p.second_y = by[31:0];
        p.second_z = bz[31:0];
        p.first_radius = ra[29:0];
        p.second_radius = rb[29:0];
        return p;
    endfunction

    // one register write, shadow copy updated at the same edge
    task automatic write_register(logic [IDX_W-1:0] idx, logic [32:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            REG_LENGTH_X: box_len[0] = data[LEN_W-1:0];
            REG_LENGTH_Y: box_len[1] = data[LEN_W-1:0];
            REG_LENGTH_Z: box_len[2] = data[LEN_W-1:0];
            REG_RECIP_X:  box_recip[0] = data;
            REG_RECIP_Y:  box_recip[1] = data;
            REG_RECIP_Z:  box_recip[2] = data;
            REG_CUTOFF:   cut_dist = data[CUT_W-1:0];
            default:      ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure_box(logic [32:0] lx, logic [32:0] ly, logic [32:0] lz,
                                 logic [32:0] rx, logic [32:0] ry, logic [32:0] rz,
                                 logic [32:0] cut);
        write_register(REG_LENGTH_X, lx);
        write_register(REG_LENGTH_Y, ly);
        write_register(REG_LENGTH_Z, lz);
        write_register(REG_RECIP_X, rx);
        write_register(REG_RECIP_Y, ry);
        write_register(REG_RECIP_Z, rz);
        write_register(REG_CUTOFF, cut);
    endtask

    // one input transfer; the expectation is queued at the accepting edge
    task automatic send_pair(point_pair_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, p.second_radius, p.first_radius, p.second_z, p.second_y,
                         p.second_x, p.first_z, p.first_y, p.first_x};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_separations.push_back(predict_separation(p));
    endtask

    // stop sending and let every expected result come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_separations.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // output side: random stalls and field-by-field comparison
    always @(posedge clk)
    begin : check_results
        separation_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_separations.size() == 0)
            begin
                $error("result transfer with no expectation pending");
                error_count++;
            end
            else
            begin
                want = expected_separations.pop_front();
                if (m_axis_tdata[31:0] !== want.sep_x)
                begin
                    $error("sep_x expected %0d got %0d", want.sep_x,
                           $signed(m_axis_tdata[31:0]));
                    error_count++;
                end
                if (m_axis_tdata[63:32] !== want.sep_y)
                begin
                    $error("sep_y expected %0d got %0d", want.sep_y,
                           $signed(m_axis_tdata[63:32]));
                    error_count++;
                end
                if (m_axis_tdata[95:64] !== want.sep_z)
                begin
                    $error("sep_z expected %0d got %0d", want.sep_z,
                           $signed(m_axis_tdata[95:64]));
                    error_count++;
                end
                if (m_axis_tdata[157:96] !== want.dist_sq)
                begin
                    $error("dist_sq expected %0d got %0d", want.dist_sq,
                           m_axis_tdata[157:96]);
                    error_count++;
                end
                if (m_axis_tdata[158] !== want.beyond_cutoff)
                begin
                    $error("beyond_cutoff expected %0b got %0b", want.beyond_cutoff,
                           m_axis_tdata[158]);
                    error_count++;
                end
            end
        end
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // reset box: coordinate extremes, radii extremes, tie of dist_sq with zero threshold
    task automatic test_reset_config();
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(-2147483648, -2147483648, -2147483648,
                            2147483647, 2147483647, 2147483647, 0, 0));
        send_pair(make_pair(2147483647, 2147483647, 2147483647,
                            -2147483648, -2147483648, -2147483648, 0, 0));
        send_pair(make_pair(12345, -6789, 1, 12345, -6789, 1, 30'h3FFF_FFFF, 30'h3FFF_FFFF));
        send_pair(make_pair(0, 0, 0, 1, 0, 0, 0, 0));
        wait_drained();
    endtask

    // ten-unit box: half-box edges, half ties, whole wraps, threshold tie
    task automatic test_fold_boundaries();
        longint len;
        longint half;
        len = 10 * 65536;
        half = len / 2;
        configure_box(33'(len), 33'(len), 33'(len), 33'((64'd1 << 48) / len),
                      33'((64'd1 << 48) / len), 33'((64'd1 << 48) / len), 33'd65536);
        send_pair(make_pair(0, 0, 0, half, -half, half + 1, 0, 0));
        send_pair(make_pair(0, 0, 0, -half - 1, half + 1, -half, 0, 0));
        send_pair(make_pair(100, -100, 7, 100 + len + half, -100 - len - half,
                            7 + 2 * len + half + 1, 0, 0));
        send_pair(make_pair(-5, 5, 0, -5 + 3 * len, 5 - 3 * len, 2 * len - 1, 0, 0));
        send_pair(make_pair(0, 0, 0, 131072, 0, 0, 32768, 32768));
        send_pair(make_pair(0, 0, 0, 131073, 0, 0, 32768, 32768));
        wait_drained();
    endtask

    // zero edge, mismatched reciprocal, masked upper bits, huge threshold, unused index
    task automatic test_degenerate_boxes();
        configure_box(33'd0, 33'd65536, {2'b11, 31'h7FFF_FFFF}, 33'h1_FFFF_FFFF,
                      33'h1_FFFF_FFFF, RECIP_RESET, {2'b01, 31'h7FFF_FFFF});
        send_pair(make_pair(0, 0, 0, 0, 40 * 65536, 3, 0, 0));
        send_pair(make_pair(0, 0, 0, 5, -40 * 65536, -3, 30'h3FFF_FFFF, 30'h3FFF_FFFF));
        send_pair(make_pair(-2147483648, 0, 0, 2147483647, 2147483647, 0, 0, 0));
        wait_drained();
        write_register(REG_UNUSED, 33'h1_FFFF_FFFF);
        send_pair(make_pair(0, 0, 0, -7, 3 * 65536 + 1, 2147483647, 1, 2));
        wait_drained();
        write_register(REG_CUTOFF, 33'h0_4000_0000);
        send_pair(make_pair(0, 0, 0, 65536, 65536, 65536, 0, 0));
        wait_drained();
    endtask

    // random edge lengths, occasionally zero, extreme or inconsistent with the reciprocal
    task automatic configure_random_box();
        logic [32:0] lens [3];
        logic [32:0] rcps [3];
        logic [32:0] cut;
        longint top;
        for (int axis = 0; axis < 3; axis++)
        begin
            case ($urandom_range(9))
                0:
                begin
                    lens[axis] = '0;
                    rcps[axis] = {1'($urandom_range(1)), $urandom};
                end
                1:
                begin
                    lens[axis] = 33'd65536;
                    rcps[axis] = 33'h1_0000_0000;
                end
                2:
                begin
                    lens[axis] = 33'h0_7FFF_FFFF;
                    rcps[axis] = RECIP_RESET;
                end
                3:
                begin
                    lens[axis] = {2'($urandom_range(3)), 31'($urandom_range(32'h7FFF_FFFF))};
                    rcps[axis] = {1'($urandom_range(1)), $urandom};
                end
                default:
                begin
                    top = longint'(1) << $urandom_range(17, 31);
                    lens[axis] = 33'(pick_span(65536, top - 1));
                    rcps[axis] = 33'((64'd1 << 48) / lens[axis]);
                    // garbage above the register width must be dropped
                    if ($urandom_range(3) == 0)
                        lens[axis][32:31] = 2'($urandom_range(3));
                end
            endcase
        end
        case ($urandom_range(5))
            0: cut = '0;
            1: cut = {2'($urandom_range(3)), 31'h7FFF_FFFF};
            2: cut = 33'h0_4000_0000;
            default: cut = 33'(pick_span(0, lens[0][30:0] / 2 + 1));
        endcase
        configure_box(lens[0], lens[1], lens[2], rcps[0], rcps[1], rcps[2], cut);
        if ($urandom_range(3) == 0)
            write_register(REG_UNUSED, {1'($urandom_range(1)), $urandom});
    endtask

    // random axis difference shaped around the current edge length
    function automatic longint pick_difference(longint len);
        longint half;
        longint sgn;
        half = len / 2;
        sgn = $urandom_range(1) ? -1 : 1;
        case ($urandom_range(5))
            0: return pick_span(-3 * len - 1, 3 * len + 1);
            1: return sgn * (half + pick_span(-1, 1));
            2: return sgn * (pick_span(1, 3) * len + half + pick_span(-1, 1));
            3: return pick_span(-262144, 262144);
            4: return pick_span(-half, half);
            default: return pick_span(-64'd4294967295, 64'd4294967295);
        endcase
    endfunction

    task automatic test_random_traffic(int n_items, int s_pct, int r_pct);
        point_pair_t p;
        longint a [3];
        longint b [3];
        longint rbound;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < n_items; i++)
        begin
            // reconfigure between blocks once the pipeline is empty
            if (i % BLOCK_ITEMS == 0)
            begin
                wait_drained();
                configure_random_box();
            end
            for (int axis = 0; axis < 3; axis++)
            begin
                a[axis] = longint'($signed($urandom));
                if ($urandom_range(4) == 0)
                    b[axis] = longint'($signed($urandom));
                else
                    b[axis] = a[axis] + pick_difference(longint'(box_len[axis]));
            end
            rbound = longint'(box_len[0]) / 4;
            if (rbound > 536870912)
                rbound = 536870912;
            if ($urandom_range(4) == 0)
                p = make_pair(a[0], a[1], a[2], b[0], b[1], b[2],
                              $urandom_range(30'h3FFF_FFFF), $urandom_range(30'h3FFF_FFFF));
            else
                p = make_pair(a[0], a[1], a[2], b[0], b[1], b[2],
                              pick_span(0, rbound), pick_span(0, rbound));
            send_pair(p);
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_config();
        test_fold_boundaries();
        test_degenerate_boxes();
        test_random_traffic(250, 19, 60);
        test_random_traffic(250, 60, 19);
        test_random_traffic(250, 0, 0);
        wait_drained();
        repeat (NUM_STAGES + 4) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
